>>> hdl/plob_pkg.sv
// Package: operation codes and shared types for the price level order book.
package plob_pkg;

  localparam int LEVELS_DEF = 64;
  localparam int PRICE_W = 32;
  localparam int QTY_W = 32;
  localparam int OP_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 3'd0,
    OP_MODIFY = 3'd1,
    OP_CANCEL = 3'd2,
    OP_TRADE  = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  // broadcast from the side controller to every cell of one table
  typedef struct packed {
    logic               update;   // apply the event this cycle
    logic               clear;    // empty the table
    logic               ask;      // ordering: 1 ascending, 0 descending
    logic               do_ins;   // insert new level
    logic               do_del;   // remove level at matching price
    logic               do_set;   // overwrite quantity at match
    logic               do_add;   // saturating add at match
    logic               do_sub;   // subtract at match
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } plob_cmd_t;

  // per cell status toward the side controller
  typedef struct packed {
    logic match;
    logic le_qty;   // held quantity <= command quantity
  } plob_stat_t;

endpackage

>>> hdl/plob_cell.sv
// Sorted table cell: one price level, compares against the broadcast and shifts with neighbors.
module plob_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  plob_pkg::plob_cmd_t       cmd,
  input  logic                      prev_valid,
  input  logic [31:0]               prev_price,
  input  logic [31:0]               prev_qty,
  input  logic                      prev_behind,   // new level ranks behind previous cell
  input  logic                      prev_del_seen, // deleted level sits at or before previous
  input  logic                      next_valid,
  input  logic [31:0]               next_price,
  input  logic [31:0]               next_qty,
  output logic                      valid,
  output logic [31:0]               price,
  output logic [31:0]               qty,
  output logic                      behind,
  output logic                      del_seen,
  output plob_pkg::plob_stat_t      stat
);
  import plob_pkg::*;

  logic        match;
  logic        new_ahead;
  logic [32:0] sum;

  assign match = valid && (price == cmd.price);
  assign new_ahead = cmd.ask ? (cmd.price < price) : (cmd.price > price);
  // new level goes behind this cell when this cell is valid and not ranked after it
  assign behind = valid && !new_ahead;
  assign del_seen = prev_del_seen || match;
  assign sum = {1'b0, qty} + {1'b0, cmd.qty};
  assign stat.match = match;
  assign stat.le_qty = (qty <= cmd.qty);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.clear) begin
      valid <= 1'b0;
    end else if (cmd.update) begin
      priority if (cmd.do_ins) begin
        if (prev_behind && !behind) begin
          valid <= 1'b1;
          price <= cmd.price;
          qty <= cmd.qty;
        end else if (!prev_behind) begin
          valid <= prev_valid;
          price <= prev_price;
          qty <= prev_qty;
        end
      end else if (cmd.do_del) begin
        if (del_seen) begin
          valid <= next_valid;
          price <= next_price;
          qty <= next_qty;
        end
      end else if (match) begin
        if (cmd.do_set) qty <= cmd.qty;
        else if (cmd.do_add) qty <= sum[32] ? '1 : sum[31:0];
        else if (cmd.do_sub) qty <= qty - cmd.qty;
      end
    end
  end

endmodule

>>> hdl/plob_side.sv
// One side's table: a chain of cells plus the decode of an event into a cell command.
module plob_side #(
  parameter int LEVELS = plob_pkg::LEVELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        ask,
  input  logic        eval,        // compare phase: decide the command
  input  logic        apply,       // update phase
  input  logic        clear,
  input  logic [2:0]  op,
  input  logic        mine,        // event targets this side
  input  logic [31:0] in_price,
  input  logic [31:0] in_qty,
  output logic        top_valid,
  output logic [31:0] top_price,
  output logic [31:0] top_qty,
  output logic        dropped
);
  import plob_pkg::*;

  logic [LEVELS-1:0]  v;
  logic [31:0]        p [LEVELS];
  logic [31:0]        q [LEVELS];
  logic [LEVELS-1:0]  beh;
  logic [LEVELS-1:0]  dseen;
  plob_stat_t         st [LEVELS];
  logic [LEVELS-1:0]  m_vec;
  logic [LEVELS-1:0]  le_vec;
  plob_cmd_t          cmd;
  logic               hit, hit_le;
  logic               ins, del, setq, addq, subq;

  always_comb begin
    for (int i = 0; i < LEVELS; i++) begin
      m_vec[i] = st[i].match;
      le_vec[i] = st[i].le_qty;
    end
  end

  assign hit = |m_vec;
  assign hit_le = |(m_vec & le_vec);

  always_comb begin
    ins = 1'b0; del = 1'b0; setq = 1'b0; addq = 1'b0; subq = 1'b0;
    unique case (op)
      OP_ADD: begin
        if (mine) begin
          addq = hit;
          ins = !hit && (in_qty != '0);
        end
      end
      OP_MODIFY: begin
        if (mine) begin
          del = hit && (in_qty == '0);
          setq = hit && (in_qty != '0);
          ins = !hit && (in_qty != '0);
        end
      end
      OP_CANCEL: del = mine && hit;
      OP_TRADE: begin
        del = hit && hit_le;
        subq = hit && !hit_le;
      end
      default: ;
    endcase
  end

  // decisions registered between compare and update phases
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd.update <= 1'b0;
      cmd.clear <= 1'b0;
    end else begin
      cmd.update <= eval;
      cmd.clear <= clear;
    end
    if (eval) begin
      cmd.ask <= ask;
      cmd.do_ins <= ins;
      cmd.do_del <= del;
      cmd.do_set <= setq;
      cmd.do_add <= addq;
      cmd.do_sub <= subq;
      cmd.price <= in_price;
      cmd.qty <= in_qty;
      dropped <= ins && v[LEVELS-1];
    end
  end

  // during compare phase the cells see the live price so the match is known
  plob_cmd_t ccmd;
  always_comb begin
    ccmd = cmd;
    ccmd.ask = ask;
    ccmd.update = apply && cmd.update;
    ccmd.clear = cmd.clear;
    if (eval) begin
      ccmd.price = in_price;
      ccmd.qty = in_qty;
    end
  end

  for (genvar i = 0; i < LEVELS; i++) begin : g_cell
    logic        pv, nv, pb, pd;
    logic [31:0] pp, pq, np, nq;
    if (i == 0) begin : g_first
      assign pv = 1'b0; assign pp = '0; assign pq = '0;
      assign pb = 1'b1; assign pd = 1'b0;
    end else begin : g_mid
      assign pv = v[i-1]; assign pp = p[i-1]; assign pq = q[i-1];
      assign pb = beh[i-1]; assign pd = dseen[i-1];
    end
    if (i == LEVELS - 1) begin : g_last
      assign nv = 1'b0; assign np = '0; assign nq = '0;
    end else begin : g_nx
      assign nv = v[i+1]; assign np = p[i+1]; assign nq = q[i+1];
    end
    plob_cell u_cell (
      .clk(clk), .rst(rst), .cmd(ccmd),
      .prev_valid(pv), .prev_price(pp), .prev_qty(pq),
      .prev_behind(pb), .prev_del_seen(pd),
      .next_valid(nv), .next_price(np), .next_qty(nq),
      .valid(v[i]), .price(p[i]), .qty(q[i]),
      .behind(beh[i]), .del_seen(dseen[i]), .stat(st[i])
    );
  end

  assign top_valid = v[0];
  assign top_price = p[0];
  assign top_qty = q[0];

endmodule

>>> hdl/price_level_order_book_top.sv
// Top level: price level order book with best bid / best ask report.
//
// Input channel (in_valid/in_stall): one feed event per item, fields
// operation, price, quantity, side. Output channel (out_valid/out_stall):
// one report per event, best bid and ask with quantities, top_changed and
// level_dropped.
// Each table is a chain of LEVELS cells. In the accepting cycle of an event
// the price is broadcast to all cells and the decision (match, insertion
// point, removal) is registered; in the next the cells shift or update at
// once. The report is then loaded into the output register from the
// updated tops, and out_valid rises with it. A new event is not taken
// until the report of the previous one has left the last stage.
// The output register holds a report while out_stall is high. The next
// event may still be accepted and update the tables; its report waits in
// the last stage, and in_stall stays high until the held report is taken.
// Reset empties both tables and drops any pending report.
module price_level_order_book_top #(
  parameter int LEVELS = plob_pkg::LEVELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  operation,
  input  logic [31:0] price,
  input  logic [31:0] quantity,
  input  logic        side,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        top_changed,
  output logic [31:0] best_bid_price,
  output logic [31:0] best_bid_quantity,
  output logic [31:0] best_ask_price,
  output logic [31:0] best_ask_quantity,
  output logic        level_dropped
);
  import plob_pkg::*;

  logic        busy1, busy2;
  logic        acc;
  logic        load;
  logic        bv, av, bd, ad;
  logic [31:0] bp, bq, ap, aq;
  logic [31:0] ob_bp, ob_bq, ob_ap, ob_aq;
  logic        is_clear;

  assign in_stall = busy1 || busy2;
  assign acc = in_valid && !in_stall;
  assign is_clear = (operation == OP_CLEAR);
  // last stage waits while the output register holds an untaken report
  assign load = busy2 && !(out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy1 <= 1'b0;
      busy2 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      busy1 <= acc;
      busy2 <= busy1 || (busy2 && !load);
      if (load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
    if (acc) begin
      ob_bp <= bv ? bp : '0;
      ob_bq <= bv ? bq : '0;
      ob_ap <= av ? ap : '0;
      ob_aq <= av ? aq : '0;
    end
    if (load) begin
      best_bid_price <= bv ? bp : '0;
      best_bid_quantity <= bv ? bq : '0;
      best_ask_price <= av ? ap : '0;
      best_ask_quantity <= av ? aq : '0;
      level_dropped <= bd || ad;
      top_changed <= ((bv ? bp : '0) != ob_bp) || ((bv ? bq : '0) != ob_bq)
                  || ((av ? ap : '0) != ob_ap) || ((av ? aq : '0) != ob_aq);
    end
  end

  plob_side #(.LEVELS(LEVELS)) u_bid (
    .clk(clk), .rst(rst), .ask(1'b0), .eval(acc), .apply(busy1),
    .clear(acc && is_clear), .op(operation), .mine(!side),
    .in_price(price), .in_qty(quantity),
    .top_valid(bv), .top_price(bp), .top_qty(bq), .dropped(bd)
  );

  plob_side #(.LEVELS(LEVELS)) u_ask (
    .clk(clk), .rst(rst), .ask(1'b1), .eval(acc), .apply(busy1),
    .clear(acc && is_clear), .op(operation), .mine(side),
    .in_price(price), .in_qty(quantity),
    .top_valid(av), .top_price(ap), .top_qty(aq), .dropped(ad)
  );

endmodule
